@@ src/utf8v_pkg.sv @@
// Package for the UTF-8 text validator.
// Holds verdict and failure codes and the structs passed between modules.
// No dependencies.
package utf8v_pkg;

    // Verdict reported on the final byte of a buffer
    typedef enum logic [2:0] {
        VERDICT_VALID     = 3'd0,
        VERDICT_BAD_LEAD  = 3'd1,
        VERDICT_BAD_CONT  = 3'd2,
        VERDICT_TRUNCATED = 3'd3,
        VERDICT_ALL_ASCII = 3'd4
    } verdict_t;

    // Sticky failure cause
    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_BAD_LEAD = 2'd1,
        CAUSE_BAD_CONT = 2'd2
    } cause_t;

    // Lead byte decode result
    typedef struct packed {
        logic       bad;     // 0x80-0xBF cannot start a sequence
        logic [2:0] extra;   // continuation bytes owed
    } lead_info_t;

    // One byte request handed to the scanner
    typedef struct packed {
        logic       step;    // request advances this cycle
        logic [7:0] text;
        logic       last;    // final byte of the buffer
    } scan_req_t;

endpackage

@@ src/utf8v_lead_decode.sv @@
// Lead byte decoder for legacy 1 to 6 byte UTF-8 sequences.
// Depends on utf8v_pkg.
module utf8v_lead_decode (
    input  logic [7:0]             lead_byte,
    output utf8v_pkg::lead_info_t  info
);

    // Range compare, ASCII first, then highest codes down; 0xFE/0xFF decode as five-byte leads
    always_comb begin
        info.bad   = 1'b0;
        info.extra = 3'd0;
        priority if (lead_byte < 8'h80) begin
            info.extra = 3'd0;
        end else if (lead_byte == 8'hFC || lead_byte == 8'hFD) begin
            info.extra = 3'd5;
        end else if (lead_byte >= 8'hF8) begin
            info.extra = 3'd4;
        end else if (lead_byte >= 8'hF0) begin
            info.extra = 3'd3;
        end else if (lead_byte >= 8'hE0) begin
            info.extra = 3'd2;
        end else if (lead_byte >= 8'hC0) begin
            info.extra = 3'd1;
        end else begin
            info.bad = 1'b1;
        end
    end

endmodule

@@ src/utf8v_scan.sv @@
// Per-buffer scan state: pending continuations, ASCII flag, sticky cause.
// Produces the verdict for the byte being stepped. Depends on utf8v_pkg
// and utf8v_lead_decode.
module utf8v_scan (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  utf8v_pkg::scan_req_t   req,
    output utf8v_pkg::verdict_t    verdict
);

    logic [2:0]        pend_reg, pend_next, pend_upd;
    logic              ascii_reg, ascii_next, ascii_upd;
    utf8v_pkg::cause_t cause_reg, cause_next, cause_upd;
    utf8v_pkg::lead_info_t lead;

    utf8v_lead_decode u_lead (
        .lead_byte (req.text),
        .info      (lead)
    );

    // State after this byte; nothing changes once a failure is recorded
    always_comb begin
        pend_upd  = pend_reg;
        ascii_upd = ascii_reg;
        cause_upd = cause_reg;
        if (cause_reg == utf8v_pkg::CAUSE_NONE) begin
            ascii_upd = ascii_reg & ~req.text[7];
            if (pend_reg == 3'd0) begin
                if (lead.bad) begin
                    cause_upd = utf8v_pkg::CAUSE_BAD_LEAD;
                end else begin
                    pend_upd = lead.extra;
                end
            end else if (req.text[7:6] != 2'b10) begin
                cause_upd = utf8v_pkg::CAUSE_BAD_CONT;
            end else begin
                pend_upd = pend_reg - 3'd1;
            end
        end
    end

    // Verdict priority: failure, truncation, all ASCII, valid
    always_comb begin
        priority if (cause_upd == utf8v_pkg::CAUSE_BAD_LEAD) begin
            verdict = utf8v_pkg::VERDICT_BAD_LEAD;
        end else if (cause_upd != utf8v_pkg::CAUSE_NONE) begin
            verdict = utf8v_pkg::VERDICT_BAD_CONT;
        end else if (pend_upd != 3'd0) begin
            verdict = utf8v_pkg::VERDICT_TRUNCATED;
        end else if (ascii_upd) begin
            verdict = utf8v_pkg::VERDICT_ALL_ASCII;
        end else begin
            verdict = utf8v_pkg::VERDICT_VALID;
        end
    end

    // Final byte returns the scanner to its clean state
    always_comb begin
        pend_next  = pend_reg;
        ascii_next = ascii_reg;
        cause_next = cause_reg;
        if (req.step) begin
            if (req.last) begin
                pend_next  = 3'd0;
                ascii_next = 1'b1;
                cause_next = utf8v_pkg::CAUSE_NONE;
            end else begin
                pend_next  = pend_upd;
                ascii_next = ascii_upd;
                cause_next = cause_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 3'd0;
            ascii_reg <= 1'b1;
            cause_reg <= utf8v_pkg::CAUSE_NONE;
        end else begin
            pend_reg  <= pend_next;
            ascii_reg <= ascii_next;
            cause_reg <= cause_next;
        end
    end

endmodule

@@ src/utf8_text_validator.sv @@
// Top level of the UTF-8 text validator: input register, scanner, result
// register. Depends on utf8v_pkg and utf8v_scan.
//
// Usage:
//   Bytes of a buffer arrive on the s_ channel (s_text_byte, s_final_byte)
//   under valid/ready, one request per byte; s_final_byte marks the last.
//   One result per buffer leaves on the m_ channel: m_verdict_code and
//   m_is_utf8 (high only for valid, non-ASCII-only legacy UTF-8).
//   Throughput is one byte per clock, buffers back to back, while results are taken.
//   A final byte passes through two register stages (input register, result
//   register) before its result shows on the m_ channel.
//   Only final bytes need the result register; other bytes always move on,
//   so a stalled receiver blocks the input only when a final byte waits
//   behind an unaccepted result.
//   Reset (aresetn low, synchronous) empties both stages and returns the
//   scan state to a fresh buffer: no pending continuations, ASCII flag set,
//   no failure recorded.
module utf8_text_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_utf8,
    output logic [2:0] m_verdict_code
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_is_utf8_reg;
    logic [2:0] out_code_reg;
    logic       out_free, advance, load_out;

    utf8v_pkg::scan_req_t req;
    utf8v_pkg::verdict_t  verdict;

    // Stage handshakes
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_final_reg || out_free);
    assign load_out = advance && in_final_reg;
    assign s_ready  = !in_valid_reg || advance;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_text_byte;
            in_final_reg <= s_final_byte;
        end
    end

    // Scanner
    assign req.step = advance;
    assign req.text = in_byte_reg;
    assign req.last = in_final_reg;

    utf8v_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .verdict (verdict)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_code_reg    <= verdict;
            out_is_utf8_reg <= (verdict == utf8v_pkg::VERDICT_VALID);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_is_utf8      = out_is_utf8_reg;
    assign m_verdict_code = out_code_reg;

endmodule

@@ src/utf8v_checker.sv @@
// Port-level checks for the UTF-8 text validator, bound to the top level.
// Depends on utf8v_pkg.
module utf8v_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_is_utf8,
    input logic [2:0] m_verdict_code
);

    // Result is cleared by reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict_code)
            && $stable(m_is_utf8))
        else $error("stalled result changed");

    // Flag agrees with the code
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_utf8 == (m_verdict_code == utf8v_pkg::VERDICT_VALID)))
        else $error("is_utf8 disagrees with verdict");

    // Code is a defined verdict
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict_code == utf8v_pkg::VERDICT_VALID
            || m_verdict_code == utf8v_pkg::VERDICT_BAD_LEAD
            || m_verdict_code == utf8v_pkg::VERDICT_BAD_CONT
            || m_verdict_code == utf8v_pkg::VERDICT_TRUNCATED
            || m_verdict_code == utf8v_pkg::VERDICT_ALL_ASCII))
        else $error("undefined verdict code");

endmodule

bind utf8_text_validator utf8v_checker u_utf8v_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_is_utf8      (m_is_utf8),
    .m_verdict_code (m_verdict_code)
);

@@ tb/sv/tb_utf8_text_validator.sv @@
// Self-checking testbench for utf8_text_validator: directed table, then random buffers.
// Expected verdicts come from a local scanner of the byte stream, or from typed-in ones where chk is set.
// Depends on utf8v_pkg and the utf8_text_validator RTL.
module tb_utf8_text_validator;

    localparam int RAND_ITEMS   = 1350;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int DIR_ROWS     = 25;

    // One byte request; chk selects a typed-in verdict over the scanner's
    typedef struct packed {
        logic                chk;
        logic                utf8;
        utf8v_pkg::verdict_t code;
        logic                last;
        logic [7:0]          text;
    } byte_req_t;

    typedef struct packed {
        logic                is_utf8;
        utf8v_pkg::verdict_t code;
    } verdict_exp_t;

    // Directed requests: typed verdicts only where they are obvious
    localparam byte_req_t DIR_TAB [DIR_ROWS] = '{
        '{1'b1, 1'b0, utf8v_pkg::VERDICT_ALL_ASCII, 1'b1, 8'h00},  // lowest byte alone
        '{1'b1, 1'b0, utf8v_pkg::VERDICT_ALL_ASCII, 1'b1, 8'h7F},  // highest ASCII alone
        '{1'b1, 1'b0, utf8v_pkg::VERDICT_BAD_LEAD,  1'b1, 8'h80},  // stray continuation, low
        '{1'b1, 1'b0, utf8v_pkg::VERDICT_BAD_LEAD,  1'b1, 8'hBF},  // stray continuation, high
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'hC3},  // two-byte sequence
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b1, 8'hA9},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'hE0},  // three-byte lead cut short
        '{1'b1, 1'b0, utf8v_pkg::VERDICT_TRUNCATED, 1'b1, 8'h80},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b1, 8'hFF},  // 0xFF as five-byte lead
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'hFC},  // full six-byte sequence
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'h80},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'h80},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'h80},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'h80},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b1, 8'hBF},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'hF0},  // four-byte sequence
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'h90},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'h80},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b1, 8'h80},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'hC0},  // ASCII where cont owed
        '{1'b1, 1'b0, utf8v_pkg::VERDICT_BAD_CONT,  1'b1, 8'h41},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'h80},  // bytes after failure ignored
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b1, 8'hC3},
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b0, 8'hC3},  // failure on the final byte
        '{1'b0, 1'b0, utf8v_pkg::VERDICT_VALID,     1'b1, 8'hFF}
    };

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte    = 8'h00;
    logic       s_final_byte   = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic       m_is_utf8;
    logic [2:0] m_verdict_code;

    byte_req_t           req_q[$];
    byte_req_t           cur_req = '0;
    verdict_exp_t        verdict_q[$];
    verdict_exp_t        exp_v;
    logic                buf_done;
    utf8v_pkg::verdict_t pred_v;

    // Scanner state of the predictor
    logic [2:0]        owed_cont  = 3'd0;
    logic              ascii_only = 1'b1;
    utf8v_pkg::cause_t fail_cause = utf8v_pkg::CAUSE_NONE;

    int cycle_cnt   = 0;
    int errors      = 0;
    int bytes_in    = 0;
    int bufs_in     = 0;
    int verdict_tally [5] = '{0, 0, 0, 0, 0};

    utf8_text_validator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_utf8     (m_is_utf8),
        .m_verdict_code(m_verdict_code)
    );

    initial begin : clock_gen
        forever #6 aclk = ~aclk;
    end

    // Continuation bytes owed after a lead byte
    function automatic utf8v_pkg::lead_info_t decode_lead(input logic [7:0] b);
        utf8v_pkg::lead_info_t li;
        li = '0;
        if (b < 8'h80)       li.extra = 3'd0;
        else if (b == 8'hFC || b == 8'hFD) li.extra = 3'd5;
        else if (b >= 8'hF8) li.extra = 3'd4;
        else if (b >= 8'hF0) li.extra = 3'd3;
        else if (b >= 8'hE0) li.extra = 3'd2;
        else if (b >= 8'hC0) li.extra = 3'd1;
        else                 li.bad   = 1'b1;
        return li;
    endfunction

    // Advance the scanner by one byte; on the last byte give the verdict and restart
    task automatic scan_byte(input logic [7:0] b, input logic last,
                             output logic done, output utf8v_pkg::verdict_t v);
        utf8v_pkg::lead_info_t li;
        if (fail_cause == utf8v_pkg::CAUSE_NONE) begin
            if (b[7]) ascii_only = 1'b0;
            if (owed_cont == 3'd0) begin
                li = decode_lead(b);
                if (li.bad) fail_cause = utf8v_pkg::CAUSE_BAD_LEAD;
                else        owed_cont  = li.extra;
            end else if (b[7:6] != 2'b10) begin
                fail_cause = utf8v_pkg::CAUSE_BAD_CONT;
            end else begin
                owed_cont = owed_cont - 3'd1;
            end
        end
        done = last;
        if (fail_cause == utf8v_pkg::CAUSE_BAD_LEAD)  v = utf8v_pkg::VERDICT_BAD_LEAD;
        else if (fail_cause != utf8v_pkg::CAUSE_NONE) v = utf8v_pkg::VERDICT_BAD_CONT;
        else if (owed_cont != 3'd0)                   v = utf8v_pkg::VERDICT_TRUNCATED;
        else if (ascii_only)                          v = utf8v_pkg::VERDICT_ALL_ASCII;
        else                                          v = utf8v_pkg::VERDICT_VALID;
        if (last) begin
            owed_cont  = 3'd0;
            ascii_only = 1'b1;
            fail_cause = utf8v_pkg::CAUSE_NONE;
        end
    endtask

    // One random buffer: mostly well-formed characters, some corrupted
    task automatic build_buffer();
        logic [7:0] seq[$];
        logic [7:0] lead;
        int n_chars, len, mode;
        byte_req_t r;
        n_chars = $urandom_range(1, 6);
        for (int c = 0; c < n_chars; c++) begin
            if ($urandom_range(0, 9) < 3) begin
                seq.push_back(8'($urandom_range(0, 127)));
            end else begin
                len = $urandom_range(2, 6);
                case (len)
                    2: lead = 8'hC0 | 8'($urandom_range(0, 31));
                    3: lead = 8'hE0 | 8'($urandom_range(0, 15));
                    4: lead = 8'hF0 | 8'($urandom_range(0, 7));
                    5: lead = $urandom_range(0, 1) ? (8'hF8 | 8'($urandom_range(0, 3)))
                                                   : (8'hFE | 8'($urandom_range(0, 1)));
                    default: lead = 8'hFC | 8'($urandom_range(0, 1));
                endcase
                seq.push_back(lead);
                for (int k = 1; k < len; k++) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
        end
        mode = $urandom_range(0, 11);
        case (mode)
            0: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
            1: if (seq.size() > 1) void'(seq.pop_back());
            2: seq.insert($urandom_range(0, seq.size() - 1), 8'($urandom_range(0, 255)));
            3: foreach (seq[i]) seq[i] = seq[i] & 8'h7F;
            default: ;
        endcase
        foreach (seq[i]) begin
            r      = '0;
            r.text = seq[i];
            r.last = (i == seq.size() - 1);
            req_q.push_back(r);
        end
    endtask

    // Check results against the oldest verdict, then predict on accepted requests
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got is_utf8=%0b verdict=%0d",
                             $time, m_is_utf8, m_verdict_code);
                    errors++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_is_utf8 !== exp_v.is_utf8) begin
                        $display("%0t: is_utf8 mismatch, expected %0b, got %0b",
                                 $time, exp_v.is_utf8, m_is_utf8);
                        errors++;
                    end
                    if (m_verdict_code !== exp_v.code) begin
                        $display("%0t: verdict_code mismatch, expected %0d, got %0d",
                                 $time, exp_v.code, m_verdict_code);
                        errors++;
                    end
                    verdict_tally[exp_v.code]++;
                end
            end
            if (s_valid && s_ready) begin
                scan_byte(cur_req.text, cur_req.last, buf_done, pred_v);
                bytes_in++;
                if (buf_done) begin
                    bufs_in++;
                    if (cur_req.chk) begin
                        verdict_q.push_back('{cur_req.utf8, cur_req.code});
                    end else begin
                        verdict_q.push_back('{pred_v == utf8v_pkg::VERDICT_VALID, pred_v});
                    end
                end
            end
        end
    end

    // Receiver: changing stall patterns plus two long hold-offs
    initial begin : receiver
        int hold_left;
        int mode;
        int phase;
        logic [15:0] pat;
        logic rdy;
        hold_left = 0;
        mode      = 0;
        phase     = 0;
        pat       = 16'hA5C3;
        forever begin
            @(negedge aclk);
            if (cycle_cnt == 400 || cycle_cnt == 1600) hold_left = HOLD_CYCLES;
            if (phase == 0) begin
                mode  = $urandom_range(0, 2);
                pat   = 16'($urandom);
                phase = $urandom_range(16, 96);
            end
            phase--;
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = pat[0];
                    default: rdy = ($urandom_range(0, 3) != 0);
                endcase
            end
            pat = {pat[0], pat[15:1]};
            m_ready <= rdy;
        end
    end

    // Cycle counter ends a hung run
    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                 $time, cycle_cnt, verdict_q.size());
        $display("utf8_text_validator test failed");
        $finish;
    end

    // Main sequence: build stimulus, reset, send requests in bursts, drain
    initial begin : sender
        int idx;
        int burst_left;
        int gap;
        idx        = 0;
        burst_left = 0;
        for (int i = 0; i < DIR_ROWS; i++) req_q.push_back(DIR_TAB[i]);
        while (req_q.size() < DIR_ROWS + RAND_ITEMS) build_buffer();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        while (idx < req_q.size()) begin
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 48);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            cur_req = req_q[idx];
            s_valid      <= 1'b1;
            s_text_byte  <= cur_req.text;
            s_final_byte <= cur_req.last;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            idx++;
            burst_left--;
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d buffers over %0d cycles, with stalls and hold-offs.",
                 bytes_in, bufs_in, cycle_cnt);
        $display("Verdicts: valid %0d, bad lead %0d, bad cont %0d, truncated %0d, ASCII %0d.",
                 verdict_tally[utf8v_pkg::VERDICT_VALID],
                 verdict_tally[utf8v_pkg::VERDICT_BAD_LEAD],
                 verdict_tally[utf8v_pkg::VERDICT_BAD_CONT],
                 verdict_tally[utf8v_pkg::VERDICT_TRUNCATED],
                 verdict_tally[utf8v_pkg::VERDICT_ALL_ASCII]);
        if (errors == 0) begin
            $display("utf8_text_validator test passed");
        end else begin
            $display("utf8_text_validator test failed");
        end
        $finish;
    end

endmodule
